>>> rtl/core/nbm_pkg.sv
// ============================================================================
// nbm_pkg
// Shared types, constants and helpers for the nearest barcode matcher.
// ============================================================================
package nbm_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int MAX_CHARS   = 8;

   localparam int CODE_CHARS  = 8;
   localparam int CODE_W      = 8 * CODE_CHARS;
   localparam int SLOT_W      = 7;
   localparam int LEN_W       = 4;
   localparam int COUNT_W     = 8;
   localparam int MM_W        = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

   localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(MAX_CHARS);
   localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(MAX_CHARS);
   localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_MATCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_TIE      = 2'd2,
      STATUS_LEN_ERR  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INDEX_LENGTH = 1'b0,
      CSR_INDEX_COUNT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      func_type          func;
      logic [SLOT_W-1:0] slot;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  seq_length;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [MM_W-1:0]   mismatches;
      logic [SLOT_W-1:0] best_slot;
      logic [CODE_W-1:0] best_code;
   } rsp_type;

   // item traveling down the cell row
   typedef struct packed {
      logic              valid;
      func_type          func;
      logic [SLOT_W-1:0] slot;
      logic [CODE_W-1:0] code;
      logic              len_ok;
      logic [MM_W-1:0]   best_mm;
      logic [IDX_W-1:0]  best_idx;
      logic [CODE_W-1:0] best_code;
      logic              tie;
   } token_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len_sat;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   function automatic logic [MM_W-1:0] diff_count(logic [CODE_W-1:0] a,
                                                  logic [CODE_W-1:0] b,
                                                  logic [LEN_W-1:0]  len);
      logic [MM_W-1:0] d;
      d = '0;
      for (int j = 0; j < CODE_CHARS; j++) begin
         if ((LEN_W'(j) < len) && (a[8*j +: 8] != b[8*j +: 8])) begin
            d = d + MM_W'(1);
         end
      end
      return d;
   endfunction

   function automatic logic [CODE_W-1:0] char_mask(logic [LEN_W-1:0] len);
      logic [CODE_W-1:0] m;
      m = '0;
      for (int j = 0; j < CODE_CHARS; j++) begin
         if (LEN_W'(j) < len) begin
            m[8*j +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

>>> rtl/core/nbm_cell.sv
// ============================================================================
// nbm_cell
// One table entry of the matcher row: stores its barcode, takes loads aimed
// at it and folds its distance into the item passing by.
// ============================================================================
module nbm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [nbm_pkg::IDX_W-1:0]     cell_idx,
   input  nbm_pkg::cfg_type              cfg,
   input  nbm_pkg::token_type            up_tok,
   output nbm_pkg::token_type            dn_tok
);

   nbm_pkg::token_type               tok_ff;
   nbm_pkg::token_type               tok_in;
   logic [nbm_pkg::CODE_W-1:0]       entry_ff;
   logic [nbm_pkg::CODE_W-1:0]       entry_in;
   logic [nbm_pkg::MM_W-1:0]         mm;
   logic                             hit_load;
   logic                             active;

   always_comb begin
      mm       = nbm_pkg::diff_count(up_tok.code, entry_ff, cfg.len_sat);
      hit_load = up_tok.valid && (up_tok.func == nbm_pkg::FUNC_LOAD) &&
                 (nbm_pkg::CMP_W'(up_tok.slot) == nbm_pkg::CMP_W'(cell_idx));
      active   = up_tok.valid && (up_tok.func == nbm_pkg::FUNC_MATCH) &&
                 up_tok.len_ok &&
                 (nbm_pkg::CMP_W'(cell_idx) < nbm_pkg::CMP_W'(cfg.count));

      entry_in = hit_load ? up_tok.code : entry_ff;

      tok_in = up_tok;
      if (active) begin
         if (mm < up_tok.best_mm) begin
            tok_in.best_mm   = mm;
            tok_in.best_idx  = cell_idx;
            tok_in.best_code = entry_ff & nbm_pkg::char_mask(cfg.len_sat);
            tok_in.tie       = 1'b0;
         end else if (mm == up_tok.best_mm) begin
            tok_in.tie = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

>>> rtl/core/nearest_barcode_matcher.sv
// ============================================================================
// nearest_barcode_matcher
// Hamming-distance barcode matcher over a row of table cells.
// ----------------------------------------------------------------------------
// Items enter on req_item while start is high and busy is low; busy stays low,
// so an item may enter every cycle. A load item writes one table entry, a
// match item produces one result on rsp_item marked by rsp_valid for a single
// cycle. Both kinds travel through one cell per table entry, one cell per
// cycle, so loads and matches take effect in arrival order.
// Path: each item passes the registered cells in table order; a match result
// is then registered after the last cell and drives rsp_item and rsp_valid.
// Throughput: one item per cycle, set by the cell row, which is fully
// registered between cells.
// Configuration: csr_valid/csr_ready write channel, csr_index selects
// index_length (0) or index_count (1); write only while no item is in flight.
// Reset: synchronous; clears items in flight, index_length = 8,
// index_count = 0. Table contents are undefined until loaded.
// The receiver cannot stall; results are presented once and not held.
// ============================================================================
module nearest_barcode_matcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  nbm_pkg::req_type                   req_item,
   output logic                               rsp_valid,
   output nbm_pkg::rsp_type                   rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nbm_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [nbm_pkg::LEN_W-1:0]   len_ff;
   logic [nbm_pkg::LEN_W-1:0]   len_in;
   logic [nbm_pkg::COUNT_W-1:0] count_ff;
   logic [nbm_pkg::COUNT_W-1:0] count_in;
   nbm_pkg::cfg_type            cfg;
   nbm_pkg::token_type          head_tok;
   nbm_pkg::token_type          chain [nbm_pkg::MAX_ENTRIES+1];
   nbm_pkg::token_type          last_tok;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   nbm_pkg::rsp_type            rsp_ff;
   nbm_pkg::rsp_type            rsp_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      len_in   = len_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         case (nbm_pkg::csr_index_type'(csr_index))
            nbm_pkg::CSR_INDEX_LENGTH: len_in   = csr_data[nbm_pkg::LEN_W-1:0];
            nbm_pkg::CSR_INDEX_COUNT:  count_in = csr_data[nbm_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= nbm_pkg::LEN_RESET;
         count_ff <= nbm_pkg::COUNT_RESET;
      end else begin
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      cfg.len_sat = (len_ff > nbm_pkg::LEN_MAX) ? nbm_pkg::LEN_MAX : len_ff;
      cfg.count   = count_ff;
   end

   // item entering the row
   always_comb begin
      head_tok.valid     = start && !busy;
      head_tok.func      = req_item.func;
      head_tok.slot      = req_item.slot;
      head_tok.code      = req_item.code;
      head_tok.len_ok    = (req_item.seq_length == len_ff);
      head_tok.best_mm   = cfg.len_sat + nbm_pkg::MM_W'(1);
      head_tok.best_idx  = '0;
      head_tok.best_code = '0;
      head_tok.tie       = 1'b0;
   end

   assign chain[0] = head_tok;

   for (genvar k = 0; k < nbm_pkg::MAX_ENTRIES; k++) begin : g_cell
      nbm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (nbm_pkg::IDX_W'(k)),
         .cfg      (cfg),
         .up_tok   (chain[k]),
         .dn_tok   (chain[k+1])
      );
   end

   assign last_tok = chain[nbm_pkg::MAX_ENTRIES];

   // result formatting
   always_comb begin
      rsp_valid_in = last_tok.valid && (last_tok.func == nbm_pkg::FUNC_MATCH);
      rsp_in       = '0;
      if (!last_tok.len_ok) begin
         rsp_in.status = nbm_pkg::STATUS_LEN_ERR;
      end else if (count_ff == '0) begin
         rsp_in.status = nbm_pkg::STATUS_EMPTY;
      end else if (last_tok.tie) begin
         rsp_in.status     = nbm_pkg::STATUS_TIE;
         rsp_in.mismatches = last_tok.best_mm;
      end else begin
         rsp_in.status     = nbm_pkg::STATUS_OK;
         rsp_in.mismatches = last_tok.best_mm;
         rsp_in.best_slot  = nbm_pkg::SLOT_W'(last_tok.best_idx);
         rsp_in.best_code  = last_tok.best_code;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> verif/nearest_barcode_matcher_tb.sv
// ============================================================================
// nearest_barcode_matcher_tb
// Self-checking testbench for the nearest barcode matcher. Load and match
// items are driven through the start/busy port. A mirror of the barcode table
// and of both registers predicts every match result, and each result is
// checked field by field in arrival order. The run covers a directed part
// (reset state, unique/tie/empty/length cases, short and saturated lengths)
// and random phases under several register settings. Phases use mostly reads
// derived from table entries, plus noise, length errors and loads, with
// random input gaps everywhere except in the last phase.
// ============================================================================
module nearest_barcode_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import nbm_pkg::*;

   localparam int LATENCY     = MAX_ENTRIES + 1;
   localparam int QUIET_LIMIT = 20 * LATENCY;
   localparam logic [CODE_W-1:0] WORD_A   = 64'h5447_4341_5441_4743;
   localparam logic [CODE_W-1:0] WORD_B   = 64'h4147_4341_5441_4743;
   localparam logic [CODE_W-1:0] WORD_TIE = 64'h4347_4341_5441_4743;
   localparam logic [7:0] BASES [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_item  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   logic [CODE_W-1:0]  barcode_mirror [MAX_ENTRIES];
   bit                 loaded [MAX_ENTRIES];
   logic [LEN_W-1:0]   cur_index_length = 4'd8;
   logic [COUNT_W-1:0] cur_index_count  = 8'd0;
   rsp_type            pending_results [$];
   rsp_type            want;

   int unsigned fail_count    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned loads_sent    = 0;
   int unsigned matches_sent  = 0;
   int unsigned settings_used = 0;
   int unsigned status_seen [4] = '{default: 0};
   bit          gaps_on = 1'b1;

   always #5 clock = ~clock;

   nearest_barcode_matcher uut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_item,
      .rsp_valid,
      .rsp_item,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   function automatic int compared_chars();
      return (cur_index_length > MAX_CHARS) ? MAX_CHARS : int'(cur_index_length);
   endfunction

   function automatic int entries_in_use();
      return (cur_index_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cur_index_count);
   endfunction

   function automatic int char_diffs(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b, int n);
      int d;
      d = 0;
      for (int j = 0; j < n; j++) begin
         if (a[8*j +: 8] != b[8*j +: 8]) begin
            d++;
         end
      end
      return d;
   endfunction

   function automatic rsp_type match_outcome(req_type item);
      rsp_type r;
      int      len, cnt, best, best_mm, mm;
      bit      tie;
      r = '0;
      if (item.seq_length != cur_index_length) begin
         r.status = STATUS_LEN_ERR;
         return r;
      end
      len = compared_chars();
      cnt = entries_in_use();
      if (cnt == 0) begin
         r.status = STATUS_EMPTY;
         return r;
      end
      best    = 0;
      best_mm = len + 1;
      tie     = 1'b0;
      for (int i = 0; i < cnt; i++) begin
         mm = char_diffs(item.code, barcode_mirror[i], len);
         if (mm < best_mm) begin
            best    = i;
            best_mm = mm;
            tie     = 1'b0;
         end else if (mm == best_mm) begin
            tie = 1'b1;
         end
      end
      r.mismatches = MM_W'(best_mm);
      if (tie) begin
         r.status = STATUS_TIE;
         return r;
      end
      r.status    = STATUS_OK;
      r.best_slot = SLOT_W'(best);
      for (int j = 0; j < len; j++) begin
         r.best_code[8*j +: 8] = barcode_mirror[best][8*j +: 8];
      end
      return r;
   endfunction

   function automatic void record_item(req_type item);
      if (item.func == FUNC_LOAD) begin
         barcode_mirror[item.slot] = item.code;
         loaded[item.slot]         = 1'b1;
         loads_sent++;
      end else begin
         pending_results.push_back(match_outcome(item));
         matches_sent++;
      end
   endfunction

   function automatic req_type make_item(func_type f, int unsigned slot,
                                         logic [CODE_W-1:0] code, int unsigned len);
      req_type item;
      item.func       = f;
      item.slot       = SLOT_W'(slot);
      item.code       = code;
      item.seq_length = LEN_W'(len);
      return item;
   endfunction

   // mostly A/C/G/T characters, now and then any byte
   function automatic logic [CODE_W-1:0] barcode_word();
      logic [CODE_W-1:0] w;
      for (int j = 0; j < CODE_CHARS; j++) begin
         w[8*j +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                   : BASES[$urandom_range(0, 3)];
      end
      return w;
   endfunction

   // an entry in use with up to two substituted characters and junk above
   function automatic logic [CODE_W-1:0] near_read();
      logic [CODE_W-1:0] w;
      int                len, pos;
      len = compared_chars();
      w   = barcode_mirror[$urandom_range(0, entries_in_use() - 1)];
      for (int j = len; j < CODE_CHARS; j++) begin
         w[8*j +: 8] = 8'($urandom);
      end
      repeat ($urandom_range(0, 2)) begin
         if (len > 0) begin
            pos           = $urandom_range(0, len - 1);
            w[8*pos +: 8] = BASES[$urandom_range(0, 3)];
         end
      end
      return w;
   endfunction

   function automatic void check_field(string name, logic [CODE_W-1:0] want_v,
                                       logic [CODE_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   task automatic send_item(req_type item);
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      record_item(item);
   endtask

   task automatic pause_input(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         pause_input($urandom_range(1, 5));
      end
   endtask

   // loads still travel the cell row after the last result
   task automatic settle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_INDEX_LENGTH) begin
         cur_index_length = data[LEN_W-1:0];
      end else begin
         cur_index_count = data;
      end
      @(posedge clock);
   endtask

   task automatic configure(int unsigned len, int unsigned cnt);
      settle();
      write_csr(CSR_INDEX_LENGTH, {4'($urandom_range(0, 15)), 4'(len)});
      write_csr(CSR_INDEX_COUNT, 8'(cnt));
      settings_used++;
   endtask

   task automatic send_random_item();
      req_type     item;
      int unsigned pick;
      pick            = $urandom_range(0, 99);
      item            = '0;
      item.func       = FUNC_MATCH;
      item.slot       = SLOT_W'($urandom);
      item.seq_length = cur_index_length;
      if (pick < 12) begin
         item.func       = FUNC_LOAD;
         item.code       = barcode_word();
         item.seq_length = LEN_W'($urandom);
      end else if (pick < 22) begin
         item.seq_length = LEN_W'($urandom);
         item.code       = {$urandom, $urandom};
      end else if (pick < 32 || entries_in_use() == 0) begin
         item.code = {$urandom, $urandom};
      end else begin
         item.code = near_read();
      end
      send_item(item);
      maybe_gap();
   endtask

   task automatic fill_table();
      for (int i = 0; i < entries_in_use(); i++) begin
         if (!loaded[i]) begin
            send_item(make_item(FUNC_LOAD, i, barcode_word(), $urandom));
            maybe_gap();
         end
      end
   endtask

   task automatic test_reset_state();
      send_item(make_item(FUNC_MATCH, 0, {$urandom, $urandom}, 8));
      send_item(make_item(FUNC_MATCH, 127, '1, 15));
      send_item(make_item(FUNC_MATCH, 0, '0, 0));
   endtask

   task automatic test_nearest_entry();
      configure(8, 4);
      send_item(make_item(FUNC_LOAD, 0, '0, 0));
      send_item(make_item(FUNC_LOAD, 1, '1, 15));
      send_item(make_item(FUNC_LOAD, 2, WORD_A, 8));
      send_item(make_item(FUNC_LOAD, 3, WORD_B, 8));
      send_item(make_item(FUNC_MATCH, 0, '0, 8));
      send_item(make_item(FUNC_MATCH, 127, '1, 8));
      send_item(make_item(FUNC_MATCH, 0, WORD_A, 8));
      send_item(make_item(FUNC_MATCH, 0, WORD_TIE, 8));
      send_item(make_item(FUNC_MATCH, 0, {32'hFFFF_FFFF, 32'h0}, 8));
      send_item(make_item(FUNC_MATCH, 0, WORD_A ^ 64'h04, 8));
      send_item(make_item(FUNC_MATCH, 0, WORD_A, 7));
   endtask

   task automatic test_short_lengths();
      configure(4, 4);
      send_item(make_item(FUNC_MATCH, 0, {$urandom, WORD_A[31:0]}, 4));
      send_item(make_item(FUNC_MATCH, 0, {$urandom, 32'h0}, 4));
      send_item(make_item(FUNC_MATCH, 0, {$urandom, 32'hFFFF_FFFF}, 4));
      configure(0, 1);
      send_item(make_item(FUNC_MATCH, 0, {$urandom, $urandom}, 0));
      configure(0, 4);
      send_item(make_item(FUNC_MATCH, 0, {$urandom, $urandom}, 0));
      configure(15, 4);
      send_item(make_item(FUNC_MATCH, 0, WORD_A, 15));
      send_item(make_item(FUNC_MATCH, 0, WORD_A, 8));
      send_item(make_item(FUNC_LOAD, 127, {$urandom, $urandom}, 0));
   endtask

   task automatic test_random_phases();
      int unsigned lens   [10] = '{8, 1, 8, 0, 4, 15, 8, 6, 2, 8};
      int unsigned counts [10] = '{16, 2, 128, 3, 40, 255, 1, 64, 10, 200};
      for (int p = 0; p < 10; p++) begin
         configure(lens[p], counts[p]);
         gaps_on = (p != 9);
         fill_table();
         repeat (90) send_random_item();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no match item waiting: status %0d", rsp_item.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            status_seen[want.status]++;
            check_field("status", CODE_W'(want.status), CODE_W'(rsp_item.status));
            check_field("mismatches", CODE_W'(want.mismatches), CODE_W'(rsp_item.mismatches));
            check_field("best_slot", CODE_W'(want.best_slot), CODE_W'(rsp_item.best_slot));
            check_field("best_code", want.best_code, rsp_item.best_code);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_nearest_entry();
      test_short_lengths();
      test_random_phases();
      settle();
      $display("covered %0d items: %0d loads and %0d matches under %0d register settings",
               loads_sent + matches_sent, loads_sent, matches_sent, settings_used);
      $display("outcomes: %0d unique, %0d empty table, %0d tie, %0d length mismatch",
               status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
               status_seen[STATUS_TIE], status_seen[STATUS_LEN_ERR]);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> nearest_barcode_matcher.f
rtl/core/nbm_pkg.sv
rtl/core/nbm_cell.sv
rtl/core/nearest_barcode_matcher.sv
verif/nearest_barcode_matcher_tb.sv
